// ===== hdl/humidity_temperature_compensation_top_assert.svh =====
// Assertion macros for the humidity and temperature compensation block.
// Included by humidity_temperature_compensation_top; expects clk_i and rst_ni in scope.
`ifndef HUMIDITY_TEMPERATURE_COMPENSATION_TOP_ASSERT_SVH
`define HUMIDITY_TEMPERATURE_COMPENSATION_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define HTC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("htc assertion failed");

// Next-cycle implication, checked outside reset.
`define HTC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("htc assertion failed");

`endif

// ===== hdl/htc_pkg.sv =====
// Constants for the humidity and temperature compensation pipeline.
// No dependencies; used by humidity_temperature_compensation_top.
`default_nettype none

package htc_pkg;

  localparam int unsigned RhW    = 12;
  localparam int unsigned TempW  = 14;
  localparam int unsigned TcW    = 15;
  localparam int unsigned HcW    = 14;

  localparam int unsigned SqW    = 2 * RhW;
  localparam int unsigned ProdW  = 30;
  localparam int unsigned LinW   = 32;
  localparam int unsigned NW     = 34;
  localparam int unsigned ClampW = 30;
  localparam int unsigned QuotW  = 25;
  localparam int unsigned RecipW = 26;
  localparam int unsigned MulW   = QuotW + RecipW;

  localparam logic [TcW-1:0]     TempOffset = 15'd4000;
  localparam logic [TcW-1:0]     TempMid    = 15'd6500;
  localparam logic [15:0]        ScaleBase  = 16'd1000;
  localparam logic [30:0]        RhGain     = 31'd405000;
  localparam logic [LinW-1:0]    NOffset    = 32'd40000000;
  localparam logic [NW-1:0]      NMin       = 34'd1000000;
  localparam logic [NW-1:0]      NMax       = 34'd1000000000;

  // floor(n / 100000) = floor((n >> 5) / 3125) = ((n >> 5) * Recip) >> RecipShift
  localparam int unsigned        StepShift  = 5;
  localparam int unsigned        RecipShift = 37;
  localparam logic [RecipW-1:0]  Recip      = 26'd43980466;

endpackage

`default_nettype wire

// ===== hdl/humidity_temperature_compensation_top.sv =====
// Humidity and temperature compensation pipeline, top level.
// Depends on htc_pkg and humidity_temperature_compensation_top_assert.svh.
//
// Takes one raw humidity count and one raw temperature count per transfer and
// returns temperature in hundredths of a degree and relative humidity in
// hundredths of a percent, clamped to 0.1..100 %RH. A reading can enter every
// cycle unless a stalled output has filled the pipeline; each result passes
// through the four register stages: products, sum, clamp and scale, reciprocal multiply.
// A stalled output holds every stage that has no free slot behind it.
`default_nettype none

`include "humidity_temperature_compensation_top_assert.svh"

module humidity_temperature_compensation_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [htc_pkg::RhW-1:0]           humidity_raw_i,
  input  wire logic [htc_pkg::TempW-1:0]         temperature_raw_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic signed [htc_pkg::TcW-1:0]         temperature_centi_o,
  output logic [htc_pkg::HcW-1:0]                humidity_centi_o
);

  logic va_q, vb_q, vc_q, vd_q;
  logic ready_a, ready_b, ready_c, ready_d;

  assign ready_d    = !vd_q || out_ready_i;
  assign ready_c    = !vc_q || ready_d;
  assign ready_b    = !vb_q || ready_c;
  assign ready_a    = !va_q || ready_b;
  assign in_ready_o = ready_a;

  // Stage a: products
  logic signed [htc_pkg::TcW-1:0]    t_off;
  logic [15:0]                       scale_u;
  logic signed [16:0]                scale_s;
  logic signed [31:0]                prod_full;
  logic [30:0]                       lin_pos;
  logic signed [htc_pkg::TcW-1:0]    tc_in;

  logic [htc_pkg::SqW-1:0]           rh_sq_q;
  logic signed [htc_pkg::ProdW-1:0]  prod_q;
  logic signed [htc_pkg::LinW-1:0]   lin_q;
  logic signed [htc_pkg::TcW-1:0]    tc_a_q;

  assign t_off     = $signed({1'b0, temperature_raw_i}) - $signed(htc_pkg::TempMid);
  assign scale_u   = htc_pkg::ScaleBase + {1'b0, humidity_raw_i, 3'b000};
  assign scale_s   = $signed({1'b0, scale_u});
  assign prod_full = 32'(t_off) * 32'(scale_s);
  assign lin_pos   = 31'(humidity_raw_i) * htc_pkg::RhGain;
  assign tc_in     = $signed({1'b0, temperature_raw_i}) - $signed(htc_pkg::TempOffset);

  always_ff @(posedge clk_i) begin
    if (in_valid_i && ready_a) begin
      rh_sq_q <= htc_pkg::SqW'(humidity_raw_i) * htc_pkg::SqW'(humidity_raw_i);
      prod_q  <= $signed(prod_full[htc_pkg::ProdW-1:0]);
      lin_q   <= $signed({1'b0, lin_pos}) - $signed(htc_pkg::NOffset);
      tc_a_q  <= tc_in;
    end
  end

  // Stage b: sum of terms
  logic [28:0]                       sq28;
  logic signed [htc_pkg::NW-1:0]     n_d;
  logic signed [htc_pkg::NW-1:0]     n_q;
  logic signed [htc_pkg::TcW-1:0]    tc_b_q;

  assign sq28 = {rh_sq_q, 5'b00000} - {3'b000, rh_sq_q, 2'b00};
  assign n_d  = $signed({{(htc_pkg::NW-htc_pkg::LinW){lin_q[htc_pkg::LinW-1]}}, lin_q})
              + $signed({{(htc_pkg::NW-htc_pkg::ProdW){prod_q[htc_pkg::ProdW-1]}}, prod_q})
              - $signed({5'b00000, sq28});

  always_ff @(posedge clk_i) begin
    if (va_q && ready_b) begin
      n_q    <= n_d;
      tc_b_q <= tc_a_q;
    end
  end

  // Stage c: clamp and drop the power-of-two factor
  logic [htc_pkg::NW-1:0]            n_clamp;
  logic [htc_pkg::QuotW-1:0]         x_q;
  logic signed [htc_pkg::TcW-1:0]    tc_c_q;

  always_comb begin
    if (n_q < $signed(htc_pkg::NMin)) begin
      n_clamp = htc_pkg::NMin;
    end else if (n_q > $signed(htc_pkg::NMax)) begin
      n_clamp = htc_pkg::NMax;
    end else begin
      n_clamp = n_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vb_q && ready_c) begin
      x_q    <= n_clamp[htc_pkg::ClampW-1:htc_pkg::StepShift];
      tc_c_q <= tc_b_q;
    end
  end

  // Stage d: reciprocal multiply, output register
  logic [htc_pkg::MulW-1:0]          div_prod;
  logic [htc_pkg::HcW-1:0]           hc_q;
  logic signed [htc_pkg::TcW-1:0]    tc_d_q;

  assign div_prod = htc_pkg::MulW'(x_q) * htc_pkg::MulW'(htc_pkg::Recip);

  always_ff @(posedge clk_i) begin
    if (vc_q && ready_d) begin
      hc_q   <= div_prod[htc_pkg::RecipShift+htc_pkg::HcW-1:htc_pkg::RecipShift];
      tc_d_q <= tc_c_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else begin
      if (ready_a) va_q <= in_valid_i;
      if (ready_b) vb_q <= va_q;
      if (ready_c) vc_q <= vb_q;
      if (ready_d) vd_q <= vc_q;
    end
  end

  assign out_valid_o         = vd_q;
  assign humidity_centi_o    = hc_q;
  assign temperature_centi_o = tc_d_q;

  `HTC_ASSERT_IMP(a_hum_range, vd_q, (hc_q >= 14'd10) && (hc_q <= 14'd10000))
  `HTC_ASSERT_IMP(a_quot_range, vc_q, (x_q >= 25'd31250) && (x_q <= 25'd31250000))
  `HTC_ASSERT_NXT(a_stage_a_hold, va_q && !ready_b, va_q && $stable(prod_q) && $stable(lin_q))
  `HTC_ASSERT_NXT(a_stage_b_hold, vb_q && !ready_c, vb_q && $stable(n_q))

endmodule

`default_nettype wire
